FILE: sv/src_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// src_pkg
// Shared constants and helpers for the segment/rectangle clipper.
// ----------------------------------------------------------------------------
package src_pkg;

  // Depth of the queue between classifier front and divider back end
  localparam int QUEUE_DEPTH = 4;

  // Queue word: {hit, t0 num, t0 den, start_x, start_y, dx, dy}
  function automatic int word_bits(input int coord_bits);
    return 6 * coord_bits + 3;
  endfunction

endpackage

FILE: sv/src_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// src_front
// Edge classification: per-axis entry/exit numerators, cross-multiplied
// interval checks, and selection of the entry fraction t0 = n/d.
// ----------------------------------------------------------------------------
module src_front #(
  parameter int COORD_BITS = 16
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          in_valid,
  output logic                                          in_ready,
  input  logic signed [COORD_BITS-1:0]                  start_x,
  input  logic signed [COORD_BITS-1:0]                  start_y,
  input  logic signed [COORD_BITS-1:0]                  end_x,
  input  logic signed [COORD_BITS-1:0]                  end_y,
  input  logic signed [COORD_BITS-1:0]                  box_left,
  input  logic signed [COORD_BITS-1:0]                  box_top,
  input  logic signed [COORD_BITS-1:0]                  box_right,
  input  logic signed [COORD_BITS-1:0]                  box_bottom,
  output logic                                          q_valid,
  input  logic                                          q_ready,
  output logic [src_pkg::word_bits(COORD_BITS)-1:0]     q_word
);
  import src_pkg::*;

  localparam int C = COORD_BITS;
  localparam int PW = 2 * C + 2;

  logic en;
  logic v1, v2, v3;

  assign en       = !v3 || q_ready;
  assign in_ready = en;
  assign q_valid  = v3;

  // ---------------- stage 1: deltas and per-axis checks ----------------
  logic signed [C:0] ax_e, ay_e, bx_e, by_e, l_e, t_e, r_e, b_e;
  logic signed [C:0] dx_c, dy_c, enx_c, exx_c, eny_c, exy_c;
  logic [C-1:0]      dxa_c, dya_c;
  logic              xpos, ypos, xzero, yzero, okx, oky;

  always_comb begin
    ax_e = {start_x[C-1], start_x};
    ay_e = {start_y[C-1], start_y};
    bx_e = {end_x[C-1], end_x};
    by_e = {end_y[C-1], end_y};
    l_e  = {box_left[C-1], box_left};
    t_e  = {box_top[C-1], box_top};
    r_e  = {box_right[C-1], box_right};
    b_e  = {box_bottom[C-1], box_bottom};
    dx_c = bx_e - ax_e;
    dy_c = by_e - ay_e;
    xzero = (dx_c == '0);
    yzero = (dy_c == '0);
    xpos  = !dx_c[C] && !xzero;
    ypos  = !dy_c[C] && !yzero;
    enx_c = xpos ? l_e - ax_e : ax_e - r_e;
    exx_c = xpos ? r_e - ax_e : ax_e - l_e;
    eny_c = ypos ? t_e - ay_e : ay_e - b_e;
    exy_c = ypos ? b_e - ay_e : ay_e - t_e;
    dxa_c = dx_c[C] ? C'(-dx_c) : dx_c[C-1:0];
    dya_c = dy_c[C] ? C'(-dy_c) : dy_c[C-1:0];
    // parallel axis: start must lie between the left and right (or top and bottom) edges
    if (xzero) begin
      okx = (ax_e >= l_e) && (r_e >= ax_e);
    end else begin
      okx = (enx_c <= exx_c) && (enx_c <= $signed({1'b0, dxa_c})) && !exx_c[C];
    end
    if (yzero) begin
      oky = (ay_e >= t_e) && (b_e >= ay_e);
    end else begin
      oky = (eny_c <= exy_c) && (eny_c <= $signed({1'b0, dya_c})) && !exy_c[C];
    end
  end

  logic signed [C-1:0] ax1, ay1;
  logic signed [C:0]   dx1, dy1, enx1, exx1, eny1, exy1;
  logic [C-1:0]        dxa1, dya1;
  logic                ok1, nzx1, nzy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      ax1  <= start_x;
      ay1  <= start_y;
      dx1  <= dx_c;
      dy1  <= dy_c;
      enx1 <= enx_c;
      exx1 <= exx_c;
      eny1 <= eny_c;
      exy1 <= exy_c;
      dxa1 <= dxa_c;
      dya1 <= dya_c;
      ok1  <= okx && oky;
      nzx1 <= !xzero;
      nzy1 <= !yzero;
    end
  end

  // ---------------- stage 2: cross products ----------------
  logic signed [PW-1:0] pa2, pb2, pc2, pd2;
  logic signed [C-1:0]  ax2, ay2;
  logic signed [C:0]    dx2, dy2, enx2, eny2;
  logic [C-1:0]         dxa2, dya2;
  logic                 ok2, nzx2, nzy2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      pa2  <= enx1 * $signed({1'b0, dya1});
      pb2  <= exy1 * $signed({1'b0, dxa1});
      pc2  <= eny1 * $signed({1'b0, dxa1});
      pd2  <= exx1 * $signed({1'b0, dya1});
      ax2  <= ax1;
      ay2  <= ay1;
      dx2  <= dx1;
      dy2  <= dy1;
      enx2 <= enx1;
      eny2 <= eny1;
      dxa2 <= dxa1;
      dya2 <= dya1;
      ok2  <= ok1;
      nzx2 <= nzx1;
      nzy2 <= nzy1;
    end
  end

  // ---------------- stage 3: hit and t0 select ----------------
  logic         hit_c, candx, candy;
  logic [C-1:0] n_c, d_c;

  always_comb begin
    hit_c = ok2 && (!(nzx2 && nzy2) || ((pa2 <= pb2) && (pc2 <= pd2)));
    candx = nzx2 && (enx2 > 0);
    candy = nzy2 && (eny2 > 0);
    if (candx && (!candy || (pa2 >= pc2))) begin
      n_c = enx2[C-1:0];
      d_c = dxa2;
    end else if (candy) begin
      n_c = eny2[C-1:0];
      d_c = dya2;
    end else begin
      n_c = '0;
      d_c = C'(1);
    end
    if (!hit_c) begin
      n_c = '0;
      d_c = C'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      q_word <= {hit_c, n_c, d_c, ax2, ay2, dx2, dy2};
    end
  end

endmodule

FILE: sv/src_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// src_fifo
// Small register queue decoupling the classifier from the back end.
// ----------------------------------------------------------------------------
module src_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_word,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_word
);
  import src_pkg::*;

  localparam int PB = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CB = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PB-1:0]    wr_ptr, rd_ptr;
  logic [CB-1:0]    count;
  logic             push, pop;

  assign push_ready = (count != CB'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_word   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PB'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PB'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_word;
    end
  end

`ifndef SYNTH
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CB'(DEPTH))
    else $error("queue count above depth");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not rise on push");
  a_count_dn: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (count == $past(count) - 1'b1))
    else $error("queue count did not fall on pop");
`endif

endmodule

FILE: sv/src_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// src_back
// Back end: bit-per-stage divider for t0, rounding, and entry point
// interpolation, ending in the output register.
// ----------------------------------------------------------------------------
module src_back #(
  parameter int COORD_BITS  = 16,
  parameter int T_FRAC_BITS = 16
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      q_valid,
  output logic                                      q_ready,
  input  logic [src_pkg::word_bits(COORD_BITS)-1:0] q_word,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic                                      hit,
  output logic [T_FRAC_BITS:0]                      enter_t,
  output logic signed [COORD_BITS-1:0]              enter_x,
  output logic signed [COORD_BITS-1:0]              enter_y
);
  import src_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int T  = T_FRAC_BITS;
  localparam int QB = T + 2;          // quotient of n * 2^(T+1) / d
  localparam int NS = QB;             // one quotient bit per stage
  localparam int MW = C + T + 3;      // dx * t product

  logic en;
  assign en      = !out_valid || out_ready;
  assign q_ready = en;

  logic                w_hit;
  logic [C-1:0]        w_n, w_d;
  logic signed [C-1:0] w_ax, w_ay;
  logic signed [C:0]   w_dx, w_dy;

  assign {w_hit, w_n, w_d, w_ax, w_ay, w_dx, w_dy} = q_word;

  logic                v   [NS];
  logic [C:0]          rem [NS];
  logic [QB-1:0]       quo [NS];
  logic [C-1:0]        dv  [NS];
  logic signed [C-1:0] sax [NS];
  logic signed [C-1:0] say [NS];
  logic signed [C:0]   sdx [NS];
  logic signed [C:0]   sdy [NS];
  logic                sh  [NS];

  // first stage: n <= d, so top quotient bit is (n >= d)
  logic [C:0] r0;
  logic       ge0;
  assign r0  = {1'b0, w_n};
  assign ge0 = (r0 >= {1'b0, w_d});

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= q_valid;
    end
    if (en) begin
      rem[0] <= ge0 ? r0 - {1'b0, w_d} : r0;
      quo[0] <= {{(QB-1){1'b0}}, ge0};
      dv[0]  <= w_d;
      sax[0] <= w_ax;
      say[0] <= w_ay;
      sdx[0] <= w_dx;
      sdy[0] <= w_dy;
      sh[0]  <= w_hit;
    end
  end

  for (genvar i = 1; i < NS; i++) begin : g_div
    logic [C:0] tr;
    logic       ge;
    assign tr = {rem[i-1][C-1:0], 1'b0};
    assign ge = (tr >= {1'b0, dv[i-1]});

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (en) begin
        v[i] <= v[i-1];
      end
      if (en) begin
        rem[i] <= ge ? tr - {1'b0, dv[i-1]} : tr;
        quo[i] <= {quo[i-1][QB-2:0], ge};
        dv[i]  <= dv[i-1];
        sax[i] <= sax[i-1];
        say[i] <= say[i-1];
        sdx[i] <= sdx[i-1];
        sdy[i] <= sdy[i-1];
        sh[i]  <= sh[i-1];
      end
    end
  end

  // round half up: (Q + 1) >> 1
  logic [QB:0]         qsum;
  logic                ve, vm;
  logic [T:0]          et_e;
  logic signed [C-1:0] ax_e, ay_e, ax_m, ay_m;
  logic signed [C:0]   dx_e, dy_e;
  logic                hit_e, hit_m;
  logic [T:0]          et_m;
  logic signed [MW-1:0] px_m, py_m;

  assign qsum = {1'b0, quo[NS-1]} + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ve <= 1'b0;
      vm <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      ve <= v[NS-1];
      vm <= ve;
      out_valid <= vm;
    end
    if (en) begin
      et_e  <= sh[NS-1] ? qsum[QB-1:1] : '0;
      ax_e  <= sax[NS-1];
      ay_e  <= say[NS-1];
      dx_e  <= sdx[NS-1];
      dy_e  <= sdy[NS-1];
      hit_e <= sh[NS-1];

      px_m  <= dx_e * $signed({1'b0, et_e});
      py_m  <= dy_e * $signed({1'b0, et_e});
      ax_m  <= ax_e;
      ay_m  <= ay_e;
      et_m  <= et_e;
      hit_m <= hit_e;
    end
  end

  localparam logic signed [MW-1:0] HALF = MW'(1) <<< (T - 1);

  logic signed [MW-1:0] rx, ry;
  assign rx = (px_m + HALF) >>> T;
  assign ry = (py_m + HALF) >>> T;

  always_ff @(posedge clk) begin
    if (en) begin
      hit     <= hit_m;
      enter_t <= et_m;
      enter_x <= hit_m ? ax_m + rx[C-1:0] : '0;
      enter_y <= hit_m ? ay_m + ry[C-1:0] : '0;
    end
  end

endmodule

FILE: sv/segment_rect_clip.sv
`timescale 1ns / 1ps
// A segment passes 3 classify stages, the queue, T_FRAC_BITS+2 divider
//   stages, and round, multiply and output stages; the divider is fully
//   pipelined.
// Throughput: one segment per cycle while out_ready is high.
// Reset: synchronous rst empties all stages and the queue; data is not reset.
// ----------------------------------------------------------------------------
// segment_rect_clip
// Liang-Barsky clip of a segment against an axis-aligned rectangle.
// ----------------------------------------------------------------------------
module segment_rect_clip #(
  parameter int COORD_BITS  = 16,
  parameter int T_FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic signed [COORD_BITS-1:0] box_left,
  input  logic signed [COORD_BITS-1:0] box_top,
  input  logic signed [COORD_BITS-1:0] box_right,
  input  logic signed [COORD_BITS-1:0] box_bottom,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         hit,
  output logic [T_FRAC_BITS:0]         enter_t,
  output logic signed [COORD_BITS-1:0] enter_x,
  output logic signed [COORD_BITS-1:0] enter_y
);
  import src_pkg::*;

  localparam int W = word_bits(COORD_BITS);

  logic         f_valid, f_ready, b_valid, b_ready;
  logic [W-1:0] f_word, b_word;

  src_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .start_x    (start_x),
    .start_y    (start_y),
    .end_x      (end_x),
    .end_y      (end_y),
    .box_left   (box_left),
    .box_top    (box_top),
    .box_right  (box_right),
    .box_bottom (box_bottom),
    .q_valid    (f_valid),
    .q_ready    (f_ready),
    .q_word     (f_word)
  );

  src_fifo #(
    .WIDTH(W),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_valid(f_valid),
    .push_ready(f_ready),
    .push_word (f_word),
    .pop_valid (b_valid),
    .pop_ready (b_ready),
    .pop_word  (b_word)
  );

  src_back #(
    .COORD_BITS (COORD_BITS),
    .T_FRAC_BITS(T_FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (b_valid),
    .q_ready  (b_ready),
    .q_word   (b_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .hit      (hit),
    .enter_t  (enter_t),
    .enter_x  (enter_x),
    .enter_y  (enter_y)
  );

`ifndef SYNTH
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !hit) |-> (enter_t == '0 && enter_x == '0 && enter_y == '0))
    else $error("miss word carries nonzero payload");
  a_t_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (enter_t <= ((T_FRAC_BITS+1)'(1) << T_FRAC_BITS)))
    else $error("entry parameter above one");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(hit) && $stable(enter_t)
      && $stable(enter_x) && $stable(enter_y)))
    else $error("output word changed while stalled");
`endif

endmodule
